// ===== rtl/core/double_ended_queue_core_assert.svh =====
// Assertion macros for the deque core.
// DEQ_ASSERT checks on every rising aclk edge outside reset.
// DEQ_ASSERT_ALWAYS checks on every rising aclk edge, reset included.
`ifndef DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define DEQ_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("deque core check failed");
`define DEQ_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("deque core check failed");
`else
`define DEQ_ASSERT(lbl, prop)
`define DEQ_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== rtl/core/deq_pkg.sv =====
package deq_pkg;

    // Item width and default ring size
    localparam int DEQ_DATA_W        = 32;
    localparam int DEQ_DEPTH_DEFAULT = 16;
    localparam int DEQ_COUNT_OUT_W   = 5;

    localparam logic [DEQ_DATA_W-1:0] DEQ_NEG_ONE = '1;

    // Operation codes; six and seven are no-ops
    typedef enum logic [2:0] {
        DEQ_OP_PUSH_FRONT = 3'd0,
        DEQ_OP_PUSH_REAR  = 3'd1,
        DEQ_OP_POP_FRONT  = 3'd2,
        DEQ_OP_POP_REAR   = 3'd3,
        DEQ_OP_PEEK_FRONT = 3'd4,
        DEQ_OP_PEEK_REAR  = 3'd5
    } deq_op_t;

    // Result status codes
    typedef enum logic [1:0] {
        DEQ_ST_OK       = 2'd0,
        DEQ_ST_OVERFLOW = 2'd1,
        DEQ_ST_EMPTY    = 2'd2
    } deq_status_t;

    // Control sequencer states
    typedef enum logic {
        DEQ_IDLE = 1'b0,
        DEQ_READ = 1'b1
    } deq_state_t;

endpackage

// ===== rtl/core/deq_ram.sv =====
module deq_ram
    import deq_pkg::*;
#(
    parameter int DEPTH  = DEQ_DEPTH_DEFAULT,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                  aclk,
    input  logic                  we,
    input  logic                  re,
    input  logic [ADDR_W-1:0]     addr,
    input  logic [DEQ_DATA_W-1:0] wdata,
    output logic [DEQ_DATA_W-1:0] rdata
);

    logic [DEQ_DATA_W-1:0] mem [DEPTH];
    logic [DEQ_DATA_W-1:0] rdata_reg;

    // Single port, registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/double_ended_queue_core.sv =====
// Channel   Ports                                          Direction
// -------   ---------------------------------------------  ---------
// s_        s_valid s_ready s_op s_push_value              in
// m_        m_valid m_ready m_result_value m_status        out
//           m_item_count
//
// Pushes, no-ops and pops or peeks on an empty deque load the result register
// directly; a pop or peek that reads the entry store waits in DEQ_READ for the
// registered read of the single-port memory. One item is in flight at a time.
// Synchronous active-low reset clears pointers, occupancy and the result valid
// flag; the entry store is not cleared. A result waiting in the output register
// does not block the next transfer once m_ready is high in that cycle.
module double_ended_queue_core
    import deq_pkg::*;
#(
    parameter int DEPTH = DEQ_DEPTH_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [2:0]                   s_op,
    input  logic signed [DEQ_DATA_W-1:0] s_push_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [DEQ_DATA_W-1:0] m_result_value,
    output logic [1:0]                   m_status,
    output logic [DEQ_COUNT_OUT_W-1:0]   m_item_count
);

`include "double_ended_queue_core_assert.svh"

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(DEPTH);

    deq_state_t state_reg, state_next;
    logic [ADDR_W-1:0] front_reg, front_next;
    logic [ADDR_W-1:0] rear_reg, rear_next;
    logic [CNT_W-1:0]  occ_reg, occ_next;

    logic                       m_valid_reg, m_valid_next;
    logic [DEQ_DATA_W-1:0]      m_value_reg;
    deq_status_t                m_status_reg;
    logic [DEQ_COUNT_OUT_W-1:0] m_count_reg;

    logic                  mem_we, mem_re;
    logic [ADDR_W-1:0]     mem_addr;
    logic [DEQ_DATA_W-1:0] mem_rdata;

    logic                  load_out;
    logic [DEQ_DATA_W-1:0] out_value;
    deq_status_t           out_status;
    logic [CNT_W-1:0]      out_count;
    logic [CNT_W+DEQ_COUNT_OUT_W-1:0] out_count_ext;

    logic in_xfer, out_xfer, empty, full, push_op;
    logic [ADDR_W-1:0] front_prev, front_succ, rear_prev, rear_succ;

    // Entry store
    deq_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (s_push_value),
        .rdata (mem_rdata)
    );

    // Handshakes
    assign s_ready  = (state_reg == DEQ_IDLE) && (!m_valid_reg || m_ready);
    assign in_xfer  = s_valid && s_ready;
    assign out_xfer = m_valid_reg && m_ready;
    assign push_op  = (s_op == DEQ_OP_PUSH_FRONT) || (s_op == DEQ_OP_PUSH_REAR);

    // Ring neighbours, wrapping at DEPTH-1
    assign empty      = (occ_reg == '0);
    assign full       = (occ_reg == FULL_CNT);
    assign front_prev = (front_reg == '0) ? LAST_SLOT : front_reg - 1'b1;
    assign front_succ = (front_reg == LAST_SLOT) ? '0 : front_reg + 1'b1;
    assign rear_prev  = (rear_reg == '0) ? LAST_SLOT : rear_reg - 1'b1;
    assign rear_succ  = (rear_reg == LAST_SLOT) ? '0 : rear_reg + 1'b1;

    // Operation decode, pointer update and result selection
    always_comb begin
        state_next = state_reg;
        front_next = front_reg;
        rear_next  = rear_reg;
        occ_next   = occ_reg;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_addr   = front_reg;
        load_out   = 1'b0;
        out_value  = '0;
        out_status = DEQ_ST_OK;
        out_count  = occ_reg;

        unique case (state_reg)
            DEQ_IDLE: begin
                if (in_xfer) begin
                    unique case (deq_op_t'(s_op))
                        DEQ_OP_PUSH_FRONT: begin
                            load_out = 1'b1;
                            if (full) begin
                                out_status = DEQ_ST_OVERFLOW;
                            end else begin
                                mem_we     = 1'b1;
                                mem_addr   = front_prev;
                                front_next = front_prev;
                                occ_next   = occ_reg + 1'b1;
                                out_count  = occ_reg + 1'b1;
                            end
                        end
                        DEQ_OP_PUSH_REAR: begin
                            load_out = 1'b1;
                            if (full) begin
                                out_status = DEQ_ST_OVERFLOW;
                            end else begin
                                mem_we    = 1'b1;
                                mem_addr  = rear_reg;
                                rear_next = rear_succ;
                                occ_next  = occ_reg + 1'b1;
                                out_count = occ_reg + 1'b1;
                            end
                        end
                        DEQ_OP_POP_FRONT: begin
                            if (empty) begin
                                load_out   = 1'b1;
                                out_status = DEQ_ST_EMPTY;
                            end else begin
                                mem_re     = 1'b1;
                                mem_addr   = front_reg;
                                front_next = front_succ;
                                occ_next   = occ_reg - 1'b1;
                                state_next = DEQ_READ;
                            end
                        end
                        DEQ_OP_POP_REAR: begin
                            if (empty) begin
                                load_out   = 1'b1;
                                out_status = DEQ_ST_EMPTY;
                            end else begin
                                mem_re     = 1'b1;
                                mem_addr   = rear_prev;
                                rear_next  = rear_prev;
                                occ_next   = occ_reg - 1'b1;
                                state_next = DEQ_READ;
                            end
                        end
                        DEQ_OP_PEEK_FRONT: begin
                            if (empty) begin
                                load_out   = 1'b1;
                                out_status = DEQ_ST_EMPTY;
                                out_value  = DEQ_NEG_ONE;
                            end else begin
                                mem_re     = 1'b1;
                                mem_addr   = front_reg;
                                state_next = DEQ_READ;
                            end
                        end
                        DEQ_OP_PEEK_REAR: begin
                            if (empty) begin
                                load_out   = 1'b1;
                                out_status = DEQ_ST_EMPTY;
                                out_value  = DEQ_NEG_ONE;
                            end else begin
                                mem_re     = 1'b1;
                                mem_addr   = rear_prev;
                                state_next = DEQ_READ;
                            end
                        end
                        default: begin
                            // unused codes: no-op, count unchanged
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            DEQ_READ: begin
                // read data lands; occupancy already holds the new count
                load_out   = 1'b1;
                out_value  = mem_rdata;
                state_next = DEQ_IDLE;
            end
            default: begin
                state_next = DEQ_IDLE;
            end
        endcase
    end

    assign out_count_ext = {{DEQ_COUNT_OUT_W{1'b0}}, out_count};

    // Result slot valid
    always_comb begin
        priority if (load_out) begin
            m_valid_next = 1'b1;
        end else if (out_xfer) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= DEQ_IDLE;
            front_reg   <= '0;
            rear_reg    <= '0;
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            front_reg   <= front_next;
            rear_reg    <= rear_next;
            occ_reg     <= occ_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_value_reg  <= out_value;
            m_status_reg <= out_status;
            m_count_reg  <= out_count_ext[DEQ_COUNT_OUT_W-1:0];
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result_value = m_value_reg;
    assign m_status       = m_status_reg;
    assign m_item_count   = m_count_reg;

    // Checks
    `DEQ_ASSERT(a_occ_bound, occ_reg <= FULL_CNT)
    `DEQ_ASSERT(a_read_slot_free, (state_reg == DEQ_READ) |-> !m_valid_reg)
    `DEQ_ASSERT(a_read_one_cycle, (state_reg == DEQ_READ) |=> (state_reg == DEQ_IDLE))
    `DEQ_ASSERT(a_full_push_holds, (in_xfer && full && push_op) |=> $stable(occ_reg))

endmodule
